// ===== src/srn_pkg.sv =====
// Package for the slice range normalizer: request/result structs, codes, widths.
// No dependencies.
package srn_pkg;

  localparam int unsigned DivW = 32;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_SINGLE = 2'd1,
    ERR_RANGE  = 2'd2
  } err_e;

  typedef struct packed {
    logic signed [31:0] slice_start;
    logic signed [31:0] slice_finish;
    logic signed [31:0] slice_step;
    logic [30:0]        dim_extent;
  } req_t;

  typedef struct packed {
    logic [30:0]        first_index;
    logic signed [31:0] index_stride;
    logic [30:0]        result_count;
    logic               drop_dimension;
    logic [1:0]         error_code;
  } res_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic        do_div;
    logic [31:0] span;
    logic [31:0] mag;
    res_t        res;
  } job_t;

endpackage

// ===== src/srn_front.sv =====
// Front stage: clamp and classify one slice request into a finished result or a divide job.
// Depends on srn_pkg.
module srn_front #(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  srn_pkg::req_t req_i,
  output srn_pkg::job_t job_o
);
  import srn_pkg::*;

  localparam int unsigned SW = (INDEX_WIDTH > 34) ? INDEX_WIDTH : 34;

  logic signed [SW-1:0] st, fi, sp, dm, smin, smax, span;
  logic signed [SW-1:0] st_n, fi_n;
  logic                 err_r;

  always_comb begin
    st   = SW'(req_i.slice_start);
    fi   = SW'(req_i.slice_finish);
    sp   = SW'(req_i.slice_step);
    dm   = SW'($signed({1'b0, req_i.dim_extent}));
    smax = SW'({1'b0, {(INDEX_WIDTH-1){1'b1}}});
    smin = -smax - SW'(1);
    st_n = st;
    fi_n = fi;
    err_r = 1'b0;
    span = '0;
    job_o = '0;
    job_o.res.error_code = ERR_OK;
    if (sp == 0) begin
      // single index selection
      if (st >= 0 && st < dm) begin
        job_o.res.first_index = st[30:0];
      end else if (st < 0 && st >= -dm) begin
        st_n = st + dm;
        job_o.res.first_index = st_n[30:0];
      end else begin
        job_o.res.error_code = ERR_SINGLE;
      end
      if (job_o.res.error_code == ERR_OK) begin
        job_o.res.index_stride = 32'sd1;
        job_o.res.result_count = 31'd1;
        job_o.res.drop_dimension = 1'b1;
      end
    end else begin
      if (st >= dm) err_r = 1'b1;
      if (sp > 0) begin
        if (st < 0) st_n = (st >= -dm) ? st + dm : '0;
        if (fi > dm) fi_n = dm;
        else if (fi < 0) begin
          if (fi < -dm) err_r = 1'b1;
          fi_n = fi + dm;
        end
        span = fi_n - st_n;
      end else begin
        if (st < 0) begin
          if (st >= -dm) st_n = st + dm;
          else if (st == smin) st_n = dm - SW'(1);
          else err_r = 1'b1;
        end
        if (fi >= dm) begin
          if (fi == smax) fi_n = -SW'(1);
          else err_r = 1'b1;
        end else if (fi < 0) begin
          fi_n = (fi >= -dm) ? fi + dm : -SW'(1);
        end
        span = st_n - fi_n;
      end
      // route to the divider or finish here
      if (err_r) begin
        job_o.res.error_code = ERR_RANGE;
      end else if (span <= 0) begin
        job_o.res.index_stride = 32'sd1;
      end else begin
        job_o.do_div = 1'b1;
        job_o.span = span[31:0];
        job_o.mag = (sp > 0) ? sp[31:0] : -sp[31:0];
        job_o.res.first_index = st_n[30:0];
        job_o.res.index_stride = req_i.slice_step;
      end
    end
  end
endmodule

// ===== src/srn_fifo.sv =====
// Short queue between the front and back parts.
// Depends on srn_pkg.
module srn_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  srn_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output srn_pkg::job_t data_o
);
  import srn_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  // advance pointers and count
  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign data_o  = mem_q[rp_q];
  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
endmodule

// ===== src/srn_back.sv =====
// Back part: pipelined restoring divider computing ceil(span / mag), one bit per stage.
// Depends on srn_pkg.
module srn_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  srn_pkg::job_t job_i,
  output logic          valid_o,
  output srn_pkg::res_t res_o
);
  import srn_pkg::*;

  localparam int unsigned N = DivW;

  logic [N:0]      vld_q;
  job_t            job_q [N+1];
  logic [N:0]      rem_q [N+1];
  logic [N-1:0]    quo_q [N+1];
  logic [N-1:0]    num_q [N+1];

  // load stage: numerator span + mag - 1 fits in 32 bits unsigned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[N-1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    job_q[0] <= job_i;
    rem_q[0] <= '0;
    quo_q[0] <= '0;
    num_q[0] <= job_i.span + job_i.mag - 32'd1;
  end

  // one quotient bit per stage
  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [N:0] tr;
    always_comb tr = {rem_q[g][N-1:0], num_q[g][N-1]};
    always_ff @(posedge clk_i) begin
      job_q[g+1] <= job_q[g];
      num_q[g+1] <= {num_q[g][N-2:0], 1'b0};
      if (tr >= {1'b0, job_q[g].mag}) begin
        rem_q[g+1] <= tr - {1'b0, job_q[g].mag};
        quo_q[g+1] <= {quo_q[g][N-2:0], 1'b1};
      end else begin
        rem_q[g+1] <= tr;
        quo_q[g+1] <= {quo_q[g][N-2:0], 1'b0};
      end
    end
  end

  // drive result
  always_comb begin
    res_o = job_q[N].res;
    if (job_q[N].do_div) res_o.result_count = quo_q[N][30:0];
  end
  assign valid_o = vld_q[N];

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && job_q[0].do_div |-> job_q[0].mag != '0)
    else $error("divide job with zero magnitude");
  a_ok_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.drop_dimension |-> res_o.result_count == 31'd1)
    else $error("dropped dimension without count one");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.error_code != ERR_OK |-> res_o.result_count == '0)
    else $error("error result with nonzero count");
endmodule

// ===== src/slice_range_normalizer_top.sv =====
// Top level of the slice range normalizer: front classifier, queue, divider pipeline.
// Depends on srn_pkg, srn_front, srn_fifo, srn_back.
//
// One request is taken per cycle while busy is low; busy is never raised, since
// the divider pipeline takes an item every cycle and the receiver cannot stall.
// Each result appears on res_o with done_o high for one cycle. Its path runs
// through the queue write at the accepting edge, then one divider load stage and
// 32 one-bit divider stages.
module slice_range_normalizer_top #(
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  srn_pkg::req_t req_i,
  output logic          done_o,
  output srn_pkg::res_t res_o
);
  import srn_pkg::*;

  job_t job_f, job_b;
  logic full, empty, push, pop;

  assign busy = full;
  assign push = start && !busy;
  assign pop  = !empty;

  srn_front #(.INDEX_WIDTH(INDEX_WIDTH)) u_front (.req_i(req_i), .job_o(job_f));

  srn_fifo u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .data_i(job_f),
    .pop_i(pop), .full_o(full), .empty_o(empty), .data_o(job_b)
  );

  srn_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(pop), .job_i(job_b),
    .valid_o(done_o), .res_o(res_o)
  );
endmodule
